FILE: hw/rtl/fmqd_pkg.sv
// Shared types and constants of the FM quadrature discriminator.
package fmqd_pkg;

  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int OUT_FRAC_BITS_DEF = 12;
  localparam int SAMPLE_MAX_BITS   = 24;
  localparam int FIELD_W           = 16;
  localparam int OUT_W             = 16;
  localparam int QUOT_W            = OUT_W + 1;

  localparam logic [OUT_W-1:0] OUT_MAX = OUT_W'((2 ** (OUT_W - 1)) - 1);
  localparam logic [OUT_W-1:0] OUT_MIN = OUT_W'(2 ** (OUT_W - 1));

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_SUM,
    S_DIV_START,
    S_DIV,
    S_WRITE
  } fmqd_state_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hw/rtl/fmqd_if.sv
// Valid/ready channel interfaces for samples in and discriminator results out.
interface fmqd_in_if;
  import fmqd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] sample_i;
  logic signed [FIELD_W-1:0] sample_q;

  modport source (output valid, output sample_i, output sample_q, input ready);
  modport sink (input valid, input sample_i, input sample_q, output ready);
endinterface

interface fmqd_out_if;
  import fmqd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] demod_out;

  modport source (output valid, output demod_out, input ready);
  modport sink (input valid, input demod_out, output ready);
endinterface

FILE: hw/rtl/fmqd_mac.sv
// Shared multiplier with registered product and accumulator.
module fmqd_mac #(
  parameter int SAMPLE_BITS = fmqd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  fmqd_pkg::mac_ctl_t              ctl,
  input  logic signed [SAMPLE_BITS-1:0]   op_a,
  input  logic signed [SAMPLE_BITS-1:0]   op_b,
  output logic signed [2*SAMPLE_BITS:0]   acc
);
  import fmqd_pkg::*;

  localparam int PW = 2 * SAMPLE_BITS;

  logic signed [PW-1:0] prod;
  logic signed [PW:0]   prod_ext;
  logic signed [PW:0]   acc_next;

  assign prod_ext = {prod[PW-1], prod};

  always_comb begin
    case (ctl.acc_op)
      ACC_LOAD: acc_next = prod_ext;
      ACC_ADD:  acc_next = acc + prod_ext;
      ACC_SUB:  acc_next = acc - prod_ext;
      default:  acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= op_a * op_b;
    end
    acc <= acc_next;
  end

endmodule

FILE: hw/rtl/fmqd_div.sv
// Restoring shift-subtract divider giving a quotient with one overflow bit.
module fmqd_div #(
  parameter int SAMPLE_BITS = fmqd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           start,
  input  logic [2*SAMPLE_BITS+fmqd_pkg::QUOT_W-1:0]      dividend,
  input  logic [2*SAMPLE_BITS:0]                         divisor,
  output fmqd_pkg::div_stat_t                            stat,
  output logic [fmqd_pkg::QUOT_W-1:0]                    quot
);
  import fmqd_pkg::*;

  localparam int DW = 2 * SAMPLE_BITS + QUOT_W;
  localparam int CW = $clog2(QUOT_W);

  logic [DW-1:0] rem;
  logic [DW-1:0] dsh;
  logic [CW-1:0] cnt;
  logic          ge;
  logic [DW-1:0] diff;

  assign ge   = rem >= dsh;
  assign diff = rem - dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CW'(QUOT_W - 1);
      end else if (stat.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      dsh  <= {divisor, {(QUOT_W-1){1'b0}}};
      quot <= '0;
    end else if (stat.busy) begin
      if (ge) begin
        rem <= diff;
      end
      quot <= {quot[QUOT_W-2:0], ge};
      dsh  <= dsh >> 1;
    end
  end

endmodule

FILE: hw/rtl/fm_quadrature_discriminator_unit.sv
// FM quadrature discriminator: one I/Q pair in, one frequency estimate out.
// Each transfer on samples yields one result on demod equal to
// (Q*last_i - I*last_q) / (I*I + Q*Q), scaled by 2^OUT_FRAC_BITS, rounded to
// nearest with ties away from zero and saturated to 16 bits; a zero I or Q
// gives 0. The block takes one sample pair and takes no new pair until that
// pair's result is loaded into the output register, which waits while demod
// still holds an earlier result. The shared multiplier forms the four products
// in turn, and the restoring divider, one quotient bit per cycle over 17 steps
// with the overflow bit, takes most of that time. A finished result waits in
// the output register while the next pair is taken.
module fm_quadrature_discriminator_unit #(
  parameter int SAMPLE_BITS   = fmqd_pkg::SAMPLE_BITS_DEF,
  parameter int OUT_FRAC_BITS = fmqd_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  fmqd_in_if.sink      samples,
  fmqd_out_if.source   demod
);
  import fmqd_pkg::*;

  localparam int PW = 2 * SAMPLE_BITS;
  localparam int DW = PW + QUOT_W;

  fmqd_state_t state;
  fmqd_state_t state_next;

  logic [SAMPLE_MAX_BITS-1:0]    ext_i;
  logic [SAMPLE_MAX_BITS-1:0]    ext_q;
  logic signed [SAMPLE_BITS-1:0] cur_i;
  logic signed [SAMPLE_BITS-1:0] cur_q;
  logic signed [SAMPLE_BITS-1:0] last_i;
  logic signed [SAMPLE_BITS-1:0] last_q;
  logic signed [PW:0]            num;
  logic signed [PW:0]            acc;

  mac_ctl_t                      mac_ctl;
  logic signed [SAMPLE_BITS-1:0] op_a;
  logic signed [SAMPLE_BITS-1:0] op_b;

  logic                          div_start;
  div_stat_t                     div_stat;
  logic [QUOT_W-1:0]             quot;
  logic [PW:0]                   mag_full;
  logic [PW-1:0]                 den;
  logic [DW-1:0]                 dividend;
  logic [PW:0]                   divisor;

  logic                          neg;
  logic                          zero;
  logic [OUT_W-1:0]              q_lo;
  logic [OUT_W-1:0]              result;
  logic                          out_load;
  logic                          out_valid;
  logic [OUT_W-1:0]              out_data;

  assign ext_i = {{(SAMPLE_MAX_BITS-FIELD_W){1'b0}}, samples.sample_i};
  assign ext_q = {{(SAMPLE_MAX_BITS-FIELD_W){1'b0}}, samples.sample_q};

  assign samples.ready = (state == S_IDLE);

  fmqd_mac #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  assign neg      = num[PW];
  assign mag_full = neg ? (~num + 1'b1) : num;
  assign den      = acc[PW-1:0];
  assign dividend = (DW'(mag_full[PW-1:0]) << (OUT_FRAC_BITS + 1)) + DW'(den);
  assign divisor  = {den, 1'b0};

  fmqd_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .stat     (div_stat),
    .quot     (quot)
  );

  always_comb begin
    state_next = state;
    mac_ctl    = '{mul_en: 1'b0, acc_op: ACC_HOLD};
    op_a       = cur_q;
    op_b       = last_i;
    div_start  = 1'b0;
    case (state)
      S_IDLE: begin
        if (samples.valid) begin
          state_next = S_MUL0;
        end
      end
      S_MUL0: begin
        mac_ctl    = '{mul_en: 1'b1, acc_op: ACC_HOLD};
        state_next = S_MUL1;
      end
      S_MUL1: begin
        op_a       = cur_i;
        op_b       = last_q;
        mac_ctl    = '{mul_en: 1'b1, acc_op: ACC_LOAD};
        state_next = S_MUL2;
      end
      S_MUL2: begin
        op_a       = cur_i;
        op_b       = cur_i;
        mac_ctl    = '{mul_en: 1'b1, acc_op: ACC_SUB};
        state_next = S_MUL3;
      end
      S_MUL3: begin
        op_a       = cur_q;
        op_b       = cur_q;
        mac_ctl    = '{mul_en: 1'b1, acc_op: ACC_LOAD};
        state_next = S_SUM;
      end
      S_SUM: begin
        mac_ctl    = '{mul_en: 1'b0, acc_op: ACC_ADD};
        state_next = S_DIV_START;
      end
      S_DIV_START: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (!out_valid || demod.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign zero = (cur_i == '0) || (cur_q == '0);
  assign q_lo = quot[OUT_W-1:0];

  always_comb begin
    if (zero) begin
      result = '0;
    end else if (neg) begin
      if (quot[QUOT_W-1] || (q_lo > OUT_MIN)) begin
        result = OUT_MIN;
      end else begin
        result = ~q_lo + 1'b1;
      end
    end else begin
      if (quot[QUOT_W-1] || q_lo[OUT_W-1]) begin
        result = OUT_MAX;
      end else begin
        result = q_lo;
      end
    end
  end

  assign out_load = (state == S_WRITE) && (!out_valid || demod.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      last_i    <= '0;
      last_q    <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
        last_i    <= cur_i;
        last_q    <= cur_q;
      end else if (demod.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      cur_i <= ext_i[SAMPLE_BITS-1:0];
      cur_q <= ext_q[SAMPLE_BITS-1:0];
    end
    if (state == S_MUL3) begin
      num <= acc;
    end
    if (out_load) begin
      out_data <= result;
    end
  end

  assign demod.valid     = out_valid;
  assign demod.demod_out = out_data;

endmodule

FILE: hw/rtl/fmqd_checker.sv
// Port-level checks of the discriminator, bound to the top level.
module fmqd_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after a transfer");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared one cycle after input transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before transfer");

endmodule

bind fm_quadrature_discriminator_unit fmqd_checker u_fmqd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (demod.valid),
  .out_ready (demod.ready)
);

FILE: tb/sv/fm_quadrature_discriminator_unit_tb.sv
// Self-checking testbench of the FM quadrature discriminator unit.
`timescale 1ns / 1ps

module fm_quadrature_discriminator_unit_tb;
  import fmqd_pkg::*;

  localparam int FRAC_BITS     = OUT_FRAC_BITS_DEF;
  localparam int N_RANDOM      = 530;
  localparam int STALL_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int HOLD_AFTER    = 150;
  localparam int HOLD_CYCLES   = 400;

  typedef logic signed [FIELD_W-1:0] sample_t;
  typedef logic signed [OUT_W-1:0]   demod_t;

  typedef struct packed {
    sample_t i;
    sample_t q;
  } iq_pair_t;

  logic clk;
  logic rst;

  fmqd_in_if  samples_ch ();
  fmqd_out_if demod_ch ();

  fm_quadrature_discriminator_unit dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .demod   (demod_ch)
  );

  iq_pair_t pending_pairs[$];
  demod_t   expected_demod[$];
  sample_t  last_i;
  sample_t  last_q;
  bit       in_xfer;
  int       pairs_taken;
  int       fail_count;
  int       idle_cycles;
  int       burst_left;
  int       gap_left;
  int       hold_left;
  bit       hold_done;
  int       window_left;
  int       stall_mode;
  int       stall_phase;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Frequency estimate for the current pair against the previous one.
  function automatic demod_t freq_estimate(input sample_t ci, input sample_t cq,
                                           input sample_t pi, input sample_t pq);
    longint num;
    longint den;
    longint mag;
    longint quo;
    if (ci == 0 || cq == 0) return '0;
    num = longint'(cq) * longint'(pi) - longint'(ci) * longint'(pq);
    den = longint'(ci) * longint'(ci) + longint'(cq) * longint'(cq);
    mag = (num < 0) ? -num : num;
    quo = (2 * (mag <<< FRAC_BITS) + den) / (2 * den);
    if (num < 0) return (quo > 32768) ? demod_t'(OUT_MIN) : demod_t'(-quo);
    return (quo > 32767) ? demod_t'(OUT_MAX) : demod_t'(quo);
  endfunction

  function automatic sample_t clip_sample(input int v);
    if (v > 32767) return sample_t'(32767);
    if (v < -32768) return sample_t'(-32768);
    return sample_t'(v);
  endfunction

  function automatic sample_t rand_sample(input int mode, input sample_t prev);
    int pick;
    case (mode)
      0: return sample_t'($urandom);
      1: return sample_t'(int'($urandom_range(0, 16)) - 8);
      2: begin
        pick = $urandom_range(0, 5);
        case (pick)
          0: return sample_t'(32767);
          1: return sample_t'(-32768);
          2: return sample_t'(1);
          3: return sample_t'(-1);
          4: return sample_t'(0);
          default: return sample_t'(4096);
        endcase
      end
      default: return clip_sample(int'(prev) + int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  task automatic push_pair(input int i, input int q);
    iq_pair_t p;
    p.i = sample_t'(i);
    p.q = sample_t'(q);
    pending_pairs.push_back(p);
  endtask

  task automatic fill_stimulus();
    iq_pair_t p;
    sample_t  ri;
    sample_t  rq;
    int       mode;
    // extremes, zero components, saturation both ways
    push_pair(0, 0);
    push_pair(32767, 32767);
    push_pair(-32768, -32768);
    push_pair(-32768, 32767);
    push_pair(1, 1);
    push_pair(32767, -32768);
    push_pair(1, 1);
    push_pair(0, 5);
    push_pair(5, 0);
    push_pair(0, 32767);
    push_pair(-1, 0);
    push_pair(-1, -1);
    push_pair(1, -1);
    // exact halves round away from zero
    push_pair(5, 2);
    push_pair(4096, 4096);
    push_pair(2, 5);
    push_pair(4096, 4096);
    push_pair(32767, 1);
    push_pair(-32768, -1);
    push_pair(12345, -23456);
    ri = '0;
    rq = '0;
    for (int n = 0; n < N_RANDOM; n++) begin
      mode = $urandom_range(0, 9);
      mode = (mode < 4) ? 0 : (mode < 6) ? 1 : (mode < 7) ? 2 : 3;
      ri = rand_sample(mode, ri);
      rq = rand_sample(mode, rq);
      p.i = ri;
      p.q = rq;
      pending_pairs.push_back(p);
    end
  endtask

  // Sender: bursts of transfers separated by random gaps.
  always @(negedge clk) begin
    iq_pair_t nxt;
    logic     v;
    if (rst) begin
      samples_ch.valid <= 1'b0;
    end else if (!(samples_ch.valid && !in_xfer)) begin
      v = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_pairs.size() != 0) begin
        nxt = pending_pairs.pop_front();
        samples_ch.sample_i <= nxt.i;
        samples_ch.sample_q <= nxt.q;
        v = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left--;
        end
      end
      samples_ch.valid <= v;
    end
  end

  // Receiver: stall pattern per window, plus one long hold-off mid-run.
  always @(negedge clk) begin
    logic r;
    if (rst) begin
      demod_ch.ready <= 1'b0;
    end else begin
      if (!hold_done && pairs_taken >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (window_left == 0) begin
        window_left = $urandom_range(20, 120);
        stall_mode = $urandom_range(0, 3);
      end
      window_left--;
      stall_phase++;
      case (stall_mode)
        0: r = 1'b1;
        1: r = 1'($urandom_range(0, 1));
        2: r = (stall_phase % 3 == 0);
        default: r = ($urandom_range(0, 7) != 0);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        r = 1'b0;
      end
      demod_ch.ready <= r;
    end
  end

  // Transfer monitor, predictor and watchdog.
  always @(posedge clk) begin
    demod_t want;
    bit     busy;
    in_xfer = !rst && samples_ch.valid && samples_ch.ready;
    if (rst) begin
      last_i = '0;
      last_q = '0;
    end else begin
      if (in_xfer) begin
        expected_demod.push_back(freq_estimate(samples_ch.sample_i, samples_ch.sample_q,
                                               last_i, last_q));
        last_i = samples_ch.sample_i;
        last_q = samples_ch.sample_q;
        pairs_taken++;
      end
      if (demod_ch.valid && demod_ch.ready) begin
        if (expected_demod.size() == 0) begin
          $error("demod_out: unexpected transfer, actual %0d", demod_ch.demod_out);
          fail_count++;
        end else begin
          want = expected_demod.pop_front();
          if (demod_ch.demod_out !== want) begin
            $error("demod_out: expected %0d, actual %0d", want, demod_ch.demod_out);
            fail_count++;
          end
        end
      end
      busy = pending_pairs.size() != 0 || samples_ch.valid || expected_demod.size() != 0;
      if (in_xfer || (demod_ch.valid && demod_ch.ready) || !busy) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    samples_ch.valid = 1'b0;
    samples_ch.sample_i = '0;
    samples_ch.sample_q = '0;
    demod_ch.ready = 1'b0;
    in_xfer = 1'b0;
    pairs_taken = 0;
    fail_count = 0;
    idle_cycles = 0;
    burst_left = 1;
    gap_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    window_left = 0;
    stall_mode = 0;
    stall_phase = 0;
    fill_stimulus();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    while (pending_pairs.size() != 0 || samples_ch.valid) @(posedge clk);
    while (expected_demod.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
